>>> hw/rtl/evug_pkg.sv
package evug_pkg;

   localparam int BLOCK_FRAMES_MAX_DEFAULT = 2048;

   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 31;
   localparam int THR_W = 15;
   localparam int THR_SQ_W = 2 * THR_W;
   localparam int COUNT_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_MODE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_BLOCKS_NEEDED = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEECH_BLOCKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BLOCKS = 3'd4;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd120;
   localparam logic MIX_MODE_RESET = 1'b0;
   localparam logic [7:0] SILENCE_BLOCKS_RESET = 8'd8;
   localparam logic [7:0] MIN_SPEECH_RESET = 8'd3;
   localparam logic [COUNT_W-1:0] MAX_BLOCKS_RESET = 16'd100;

   localparam logic MIX_AVERAGE = 1'b0;
   localparam logic MIX_LOUDER = 1'b1;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_ABORT = 1'b1;

   localparam logic [1:0] STATUS_RUNNING = 2'd0;
   localparam logic [1:0] STATUS_VALID = 2'd1;
   localparam logic [1:0] STATUS_NO_SPEECH = 2'd2;
   localparam logic [1:0] STATUS_ABORTED = 2'd3;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] left_sample;
      logic [SAMPLE_W-1:0] right_sample;
      logic                last_of_block;
      logic                key_holdoff;
   } req_type;

   typedef struct packed {
      logic                abort;
      logic [SAMPLE_W-1:0] mono;
      logic [SQUARE_W-1:0] square;
      logic                last_of_block;
      logic                key_holdoff;
   } mid_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mono_sample;
      logic                block_closed;
      logic                block_loud;
      logic                keep_block;
      logic                speech_start;
      logic [1:0]          end_status;
   } rsp_type;

   typedef struct packed {
      logic [THR_SQ_W-1:0] threshold_sq;
      logic [7:0]          silence_blocks_needed;
      logic [7:0]          min_speech_blocks;
      logic [COUNT_W-1:0]  max_blocks;
   } gate_cfg_type;

endpackage

>>> hw/rtl/evug_front.sv
module evug_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  evug_pkg::req_type    req_in,
   input  logic                 mix_mode,
   output logic                 mid_valid,
   input  logic                 mid_ready,
   output evug_pkg::mid_type    mid_out
);

   logic                 req_v_ff;
   evug_pkg::req_type    req_ff;
   logic                 mid_v_ff;
   evug_pkg::mid_type    mid_ff;
   evug_pkg::mid_type    mid_in;
   logic                 mid_adv;
   logic                 req_adv;

   logic signed [16:0]   pair_sum;
   logic signed [16:0]   pair_adj;
   logic signed [16:0]   left_ext;
   logic signed [16:0]   right_ext;
   logic [16:0]          left_mag;
   logic [16:0]          right_mag;
   logic signed [15:0]   mono;
   logic signed [31:0]   square;

   assign mid_adv = !mid_v_ff || mid_ready;
   assign req_adv = !req_v_ff || mid_adv;
   assign req_stall = !req_adv;

   always_comb begin
      left_ext = $signed({req_ff.left_sample[15], req_ff.left_sample});
      right_ext = $signed({req_ff.right_sample[15], req_ff.right_sample});
      pair_sum = left_ext + right_ext;
      // round toward zero: bias odd negative sums up by one
      pair_adj = pair_sum + $signed({16'b0, pair_sum[16] & pair_sum[0]});
      left_mag = left_ext[16] ? 17'(-left_ext) : 17'(left_ext);
      right_mag = right_ext[16] ? 17'(-right_ext) : 17'(right_ext);
      if (mix_mode == evug_pkg::MIX_LOUDER) begin
         mono = (left_mag >= right_mag) ? $signed(req_ff.left_sample)
                                        : $signed(req_ff.right_sample);
      end else begin
         mono = pair_adj[16:1];
      end
      square = mono * mono;

      mid_in.abort = (req_ff.kind == evug_pkg::KIND_ABORT);
      mid_in.mono = mono;
      mid_in.square = square[30:0];
      mid_in.last_of_block = req_ff.last_of_block;
      mid_in.key_holdoff = req_ff.key_holdoff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
         mid_v_ff <= 1'b0;
      end else begin
         if (req_adv) begin
            req_v_ff <= req_valid;
         end
         if (mid_adv) begin
            mid_v_ff <= req_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_adv && req_valid) begin
         req_ff <= req_in;
      end
      if (mid_adv && req_v_ff) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_v_ff;
   assign mid_out = mid_ff;

endmodule

>>> hw/rtl/evug_core.sv
module evug_core #(
   parameter int BLOCK_FRAMES_MAX = evug_pkg::BLOCK_FRAMES_MAX_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  evug_pkg::gate_cfg_type   cfg,
   input  logic                     mid_valid,
   output logic                     mid_ready,
   input  evug_pkg::mid_type        mid_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output evug_pkg::rsp_type        rsp_out
);

   localparam int FW = $clog2(BLOCK_FRAMES_MAX);
   localparam int DW = $clog2(BLOCK_FRAMES_MAX) + 32;
   localparam int CW = evug_pkg::COUNT_W;

   localparam logic PHASE_LISTEN = 1'b0;
   localparam logic PHASE_SPEAK = 1'b1;

   logic                  phase_ff, phase_in;
   logic signed [DW-1:0]  diff_ff, diff_in, diff_sum;
   logic [FW-1:0]         frames_ff, frames_in;
   logic [CW-1:0]         blocks_ff, blocks_in;
   logic [CW-1:0]         loud_ff, loud_in;
   logic [CW-1:0]         quiet_ff, quiet_in;
   logic                  out_v_ff;
   evug_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  out_ready;
   logic                  take;
   logic                  close;
   logic                  loud;
   logic                  ended;
   logic [1:0]            status;

   assign out_ready = !out_v_ff || !rsp_stall;
   assign mid_ready = out_ready;
   assign take = mid_valid && out_ready;

   always_comb begin
      // running energy minus threshold^2 * frames; sign gives the compare
      diff_sum = diff_ff
               + $signed({{(DW - evug_pkg::SQUARE_W){1'b0}}, mid_in.square})
               - $signed({{(DW - evug_pkg::THR_SQ_W){1'b0}}, cfg.threshold_sq});
      loud = !diff_sum[DW-1];
      close = mid_in.last_of_block || (frames_ff == FW'(BLOCK_FRAMES_MAX - 1));

      phase_in = phase_ff;
      diff_in = diff_ff;
      frames_in = frames_ff;
      blocks_in = blocks_ff;
      loud_in = loud_ff;
      quiet_in = quiet_ff;
      rsp_in = '0;
      ended = 1'b0;
      status = evug_pkg::STATUS_RUNNING;

      if (take) begin
         if (mid_in.abort) begin
            ended = 1'b1;
            status = evug_pkg::STATUS_ABORTED;
         end else begin
            rsp_in.mono_sample = mid_in.mono;
            if (!close) begin
               frames_in = frames_ff + FW'(1);
               diff_in = diff_sum;
            end else begin
               frames_in = '0;
               diff_in = '0;
               blocks_in = blocks_ff + CW'(1);
               rsp_in.block_closed = 1'b1;
               rsp_in.block_loud = loud;
               if (phase_ff == PHASE_LISTEN) begin
                  if (!mid_in.key_holdoff && loud) begin
                     phase_in = PHASE_SPEAK;
                     loud_in = CW'(1);
                     quiet_in = '0;
                     rsp_in.keep_block = 1'b1;
                     rsp_in.speech_start = 1'b1;
                  end
               end else begin
                  rsp_in.keep_block = 1'b1;
                  if (loud) begin
                     loud_in = loud_ff + CW'(1);
                     quiet_in = '0;
                  end else begin
                     quiet_in = quiet_ff + CW'(1);
                     if (quiet_in >= {8'b0, cfg.silence_blocks_needed} &&
                         loud_ff >= {8'b0, cfg.min_speech_blocks}) begin
                        ended = 1'b1;
                        status = evug_pkg::STATUS_VALID;
                     end
                  end
               end
               if (!ended && blocks_in >= cfg.max_blocks) begin
                  ended = 1'b1;
                  status = (phase_in == PHASE_SPEAK &&
                            loud_in >= {8'b0, cfg.min_speech_blocks})
                         ? evug_pkg::STATUS_VALID : evug_pkg::STATUS_NO_SPEECH;
               end
            end
         end
         if (ended) begin
            rsp_in.end_status = status;
            phase_in = PHASE_LISTEN;
            diff_in = '0;
            frames_in = '0;
            blocks_in = '0;
            loud_in = '0;
            quiet_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_LISTEN;
         diff_ff <= '0;
         frames_ff <= '0;
         blocks_ff <= '0;
         loud_ff <= '0;
         quiet_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         diff_ff <= diff_in;
         frames_ff <= frames_in;
         blocks_ff <= blocks_in;
         loud_ff <= loud_in;
         quiet_ff <= quiet_in;
         if (out_ready) begin
            out_v_ff <= mid_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out = rsp_ff;

endmodule

>>> hw/rtl/energy_vad_utterance_gate.sv
// Energy-threshold voice activity gate. One stereo frame (or an abort) is
// taken per clock while req_stall is low, and exactly one result comes back
// for it through the front request and mid registers and then the core
// response register; the front stage mixes to mono and squares it in one
// multiplier, the back stage keeps a running "energy minus threshold squared
// times frames" accumulator, so the loudness decision at block close costs
// one adder per frame. A block closes on last_of_block or when it reaches
// BLOCK_FRAMES_MAX frames. Write the control registers only while no item
// is in flight; the squared threshold is registered from the threshold
// register, so it is refreshed after the threshold itself.
module energy_vad_utterance_gate #(
   parameter int BLOCK_FRAMES_MAX = evug_pkg::BLOCK_FRAMES_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic signed [evug_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [evug_pkg::SAMPLE_W-1:0] req_right_sample,
   input  logic                                req_last_of_block,
   input  logic                                req_key_holdoff,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [evug_pkg::SAMPLE_W-1:0] rsp_mono_sample,
   output logic                                rsp_block_closed,
   output logic                                rsp_block_loud,
   output logic                                rsp_keep_block,
   output logic                                rsp_speech_start,
   output logic [1:0]                          rsp_end_status,

   input  logic                                csr_wr_en,
   input  logic [evug_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [evug_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [evug_pkg::THR_W-1:0]     threshold_ff;
   logic                           mix_mode_ff;
   logic [7:0]                     silence_ff;
   logic [7:0]                     min_speech_ff;
   logic [evug_pkg::COUNT_W-1:0]   max_blocks_ff;
   logic [evug_pkg::THR_SQ_W-1:0]  threshold_sq_ff, threshold_sq_in;

   evug_pkg::req_type              req_bus;
   evug_pkg::mid_type              mid_bus;
   evug_pkg::rsp_type              rsp_bus;
   evug_pkg::gate_cfg_type         gate_cfg;
   logic                           mid_valid;
   logic                           mid_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= evug_pkg::THRESHOLD_RESET;
         mix_mode_ff <= evug_pkg::MIX_MODE_RESET;
         silence_ff <= evug_pkg::SILENCE_BLOCKS_RESET;
         min_speech_ff <= evug_pkg::MIN_SPEECH_RESET;
         max_blocks_ff <= evug_pkg::MAX_BLOCKS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            evug_pkg::CSR_ENERGY_THRESHOLD: threshold_ff <= csr_data[14:0];
            evug_pkg::CSR_MIX_MODE: mix_mode_ff <= csr_data[0];
            evug_pkg::CSR_SILENCE_BLOCKS_NEEDED: silence_ff <= csr_data[7:0];
            evug_pkg::CSR_MIN_SPEECH_BLOCKS: min_speech_ff <= csr_data[7:0];
            evug_pkg::CSR_MAX_BLOCKS: max_blocks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign threshold_sq_in = {15'b0, threshold_ff} * {15'b0, threshold_ff};

   always_ff @(posedge clock) begin
      threshold_sq_ff <= threshold_sq_in;
   end

   always_comb begin
      req_bus.kind = req_kind;
      req_bus.left_sample = req_left_sample;
      req_bus.right_sample = req_right_sample;
      req_bus.last_of_block = req_last_of_block;
      req_bus.key_holdoff = req_key_holdoff;

      gate_cfg.threshold_sq = threshold_sq_ff;
      gate_cfg.silence_blocks_needed = silence_ff;
      gate_cfg.min_speech_blocks = min_speech_ff;
      gate_cfg.max_blocks = max_blocks_ff;
   end

   evug_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in    (req_bus),
      .mix_mode  (mix_mode_ff),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_out   (mid_bus)
   );

   evug_core #(
      .BLOCK_FRAMES_MAX (BLOCK_FRAMES_MAX)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (gate_cfg),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_in    (mid_bus),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_bus)
   );

   assign rsp_mono_sample = rsp_bus.mono_sample;
   assign rsp_block_closed = rsp_bus.block_closed;
   assign rsp_block_loud = rsp_bus.block_loud;
   assign rsp_keep_block = rsp_bus.keep_block;
   assign rsp_speech_start = rsp_bus.speech_start;
   assign rsp_end_status = rsp_bus.end_status;

   a_abort_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_status == evug_pkg::STATUS_ABORTED |->
         rsp_mono_sample == 16'sd0 && !rsp_block_closed && !rsp_block_loud &&
         !rsp_keep_block && !rsp_speech_start)
      else $error("aborted item carries nonzero fields");

   a_start_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_speech_start |->
         rsp_block_closed && rsp_block_loud && rsp_keep_block)
      else $error("speech start on a block that is not loud and kept");

   a_flags_need_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_block_loud || rsp_keep_block ||
                    rsp_end_status == evug_pkg::STATUS_VALID ||
                    rsp_end_status == evug_pkg::STATUS_NO_SPEECH) |->
         rsp_block_closed)
      else $error("block flags or end status without a closed block");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      bit                    is_csr;
      logic [2:0]            idx;
      logic [15:0]           data;
      logic                  kind;
      logic [15:0]           left_s;
      logic [15:0]           right_s;
      logic                  last_blk;
      logic                  holdoff;
      bit                    pinned;
      evug_pkg::rsp_type     want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic signed [15:0] req_left_sample = '0;
   logic signed [15:0] req_right_sample = '0;
   logic        req_last_of_block = 1'b0;
   logic        req_key_holdoff = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_mono_sample;
   logic        rsp_block_closed;
   logic        rsp_block_loud;
   logic        rsp_keep_block;
   logic        rsp_speech_start;
   logic [1:0]  rsp_end_status;

   logic        csr_wr_en = 1'b0;
   logic [evug_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [evug_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   evug_pkg::rsp_type pending_gate_results[$];
   evug_pkg::rsp_type oldest_result;
   stim_row_type directed_rows[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;

   logic [14:0] cfg_thr;
   logic        cfg_mix;
   logic [7:0]  cfg_sil;
   logic [7:0]  cfg_min;
   logic [15:0] cfg_max;

   logic        st_speaking;
   logic [47:0] acc_energy;
   int          frame_cnt;
   logic [15:0] block_cnt;
   logic [15:0] loud_cnt;
   logic [15:0] quiet_cnt;

   energy_vad_utterance_gate u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_last_of_block (req_last_of_block),
      .req_key_holdoff   (req_key_holdoff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mono_sample   (rsp_mono_sample),
      .rsp_block_closed  (rsp_block_closed),
      .rsp_block_loud    (rsp_block_loud),
      .rsp_keep_block    (rsp_keep_block),
      .rsp_speech_start  (rsp_speech_start),
      .rsp_end_status    (rsp_end_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_gate_state();
      st_speaking = 1'b0;
      acc_energy  = '0;
      frame_cnt   = 0;
      block_cnt   = '0;
      loud_cnt    = '0;
      quiet_cnt   = '0;
   endfunction

   function automatic evug_pkg::rsp_type predict_gate(input logic kind,
                                                      input logic signed [15:0] l,
                                                      input logic signed [15:0] r,
                                                      input logic last_blk,
                                                      input logic holdoff);
      evug_pkg::rsp_type res;
      int          mono_i;
      int          mag_l;
      int          mag_r;
      logic [63:0] limit;
      logic        loud;
      logic        ended;
      logic [1:0]  status;
      res    = '0;
      ended  = 1'b0;
      status = evug_pkg::STATUS_RUNNING;
      if (kind == evug_pkg::KIND_ABORT) begin
         clear_gate_state();
         res.end_status = evug_pkg::STATUS_ABORTED;
         return res;
      end
      mag_l = (l < 0) ? -int'(l) : int'(l);
      mag_r = (r < 0) ? -int'(r) : int'(r);
      if (cfg_mix == evug_pkg::MIX_LOUDER) begin
         mono_i = (mag_l >= mag_r) ? int'(l) : int'(r);
      end else begin
         mono_i = (int'(l) + int'(r)) / 2;
      end
      res.mono_sample = mono_i[15:0];
      acc_energy = acc_energy + 48'(longint'(mono_i) * longint'(mono_i));
      frame_cnt++;
      if (!last_blk && frame_cnt < evug_pkg::BLOCK_FRAMES_MAX_DEFAULT) begin
         return res;
      end
      limit = 64'(cfg_thr) * 64'(cfg_thr) * 64'(frame_cnt);
      loud = ({16'd0, acc_energy} >= limit);
      acc_energy = '0;
      frame_cnt  = 0;
      block_cnt  = block_cnt + 16'd1;
      res.block_closed = 1'b1;
      res.block_loud   = loud;
      if (!st_speaking) begin
         if (!holdoff && loud) begin
            st_speaking = 1'b1;
            loud_cnt  = 16'd1;
            quiet_cnt = '0;
            res.keep_block   = 1'b1;
            res.speech_start = 1'b1;
         end
      end else begin
         res.keep_block = 1'b1;
         if (loud) begin
            loud_cnt  = loud_cnt + 16'd1;
            quiet_cnt = '0;
         end else begin
            quiet_cnt = quiet_cnt + 16'd1;
            if (quiet_cnt >= 16'(cfg_sil) && loud_cnt >= 16'(cfg_min)) begin
               ended  = 1'b1;
               status = evug_pkg::STATUS_VALID;
            end
         end
      end
      if (!ended && block_cnt >= cfg_max) begin
         ended  = 1'b1;
         status = (st_speaking && loud_cnt >= 16'(cfg_min)) ? evug_pkg::STATUS_VALID
                                                            : evug_pkg::STATUS_NO_SPEECH;
      end
      if (ended) begin
         res.end_status = status;
         clear_gate_state();
      end
      return res;
   endfunction

   function automatic evug_pkg::rsp_type exp_rsp(input int mono, input logic closed,
                                                 input logic loud, input logic keep,
                                                 input logic start,
                                                 input logic [1:0] status);
      evug_pkg::rsp_type res;
      res.mono_sample  = 16'(mono);
      res.block_closed = closed;
      res.block_loud   = loud;
      res.keep_block   = keep;
      res.speech_start = start;
      res.end_status   = status;
      return res;
   endfunction

   function automatic stim_row_type frame_row(input logic kind, input int l, input int r,
                                              input logic last_blk, input logic holdoff);
      stim_row_type row;
      row = '{default: '0};
      row.kind     = kind;
      row.left_s   = 16'(l);
      row.right_s  = 16'(r);
      row.last_blk = last_blk;
      row.holdoff  = holdoff;
      return row;
   endfunction

   function automatic stim_row_type pin(input stim_row_type row,
                                        input evug_pkg::rsp_type want);
      stim_row_type res;
      res = row;
      res.pinned = 1'b1;
      res.want   = want;
      return res;
   endfunction

   function automatic stim_row_type csr_row(input logic [2:0] idx, input int data);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx    = idx;
      row.data   = 16'(data);
      return row;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gate_results.size() == 0) begin
            $error("unexpected item: mono_sample %0d end_status %0d", rsp_mono_sample,
                   rsp_end_status);
            mismatch_count++;
         end else begin
            oldest_result = pending_gate_results.pop_front();
            if (rsp_mono_sample !== oldest_result.mono_sample) begin
               $error("mono_sample: expected %0d, actual %0d",
                      $signed(oldest_result.mono_sample), rsp_mono_sample);
               mismatch_count++;
            end
            if (rsp_block_closed !== oldest_result.block_closed) begin
               $error("block_closed: expected %0d, actual %0d", oldest_result.block_closed,
                      rsp_block_closed);
               mismatch_count++;
            end
            if (rsp_block_loud !== oldest_result.block_loud) begin
               $error("block_loud: expected %0d, actual %0d", oldest_result.block_loud,
                      rsp_block_loud);
               mismatch_count++;
            end
            if (rsp_keep_block !== oldest_result.keep_block) begin
               $error("keep_block: expected %0d, actual %0d", oldest_result.keep_block,
                      rsp_keep_block);
               mismatch_count++;
            end
            if (rsp_speech_start !== oldest_result.speech_start) begin
               $error("speech_start: expected %0d, actual %0d", oldest_result.speech_start,
                      rsp_speech_start);
               mismatch_count++;
            end
            if (rsp_end_status !== oldest_result.end_status) begin
               $error("end_status: expected %0d, actual %0d", oldest_result.end_status,
                      rsp_end_status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input logic kind, input logic [15:0] l, input logic [15:0] r,
                            input logic last_blk, input logic holdoff,
                            input bit pinned = 1'b0, input evug_pkg::rsp_type want = '0);
      evug_pkg::rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_left_sample   <= l;
      req_right_sample  <= r;
      req_last_of_block <= last_blk;
      req_key_holdoff   <= holdoff;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_gate(kind, l, r, last_blk, holdoff);
      pending_gate_results.push_back(pinned ? want : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_gate_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [evug_pkg::CSR_INDEX_W-1:0] idx, input int data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         evug_pkg::CSR_ENERGY_THRESHOLD:      cfg_thr = 15'(data);
         evug_pkg::CSR_MIX_MODE:              cfg_mix = 1'(data);
         evug_pkg::CSR_SILENCE_BLOCKS_NEEDED: cfg_sil = 8'(data);
         evug_pkg::CSR_MIN_SPEECH_BLOCKS:     cfg_min = 8'(data);
         evug_pkg::CSR_MAX_BLOCKS:            cfg_max = 16'(data);
         default: ;
      endcase
      repeat (2) @(posedge clock);
   endtask

   task automatic set_gate_cfg(input int thr, input int mix, input int sil, input int minsp,
                               input int maxb);
      settle();
      write_reg(evug_pkg::CSR_ENERGY_THRESHOLD, thr);
      write_reg(evug_pkg::CSR_MIX_MODE, mix);
      write_reg(evug_pkg::CSR_SILENCE_BLOCKS_NEEDED, sil);
      write_reg(evug_pkg::CSR_MIN_SPEECH_BLOCKS, minsp);
      write_reg(evug_pkg::CSR_MAX_BLOCKS, maxb);
   endtask

   task automatic random_phase(input int quota);
      int   sent;
      int   len;
      int   choice;
      int   m;
      int   hi;
      int   jit;
      int   a;
      int   b;
      int   t;
      bit   loud;
      logic hold;
      sent = 0;
      while (sent < quota) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
         loud = 1'($urandom_range(0, 1));
         hold = ($urandom_range(0, 99) < 15);
         for (int i = 0; i < len; i++) begin
            choice = $urandom_range(0, 99);
            if (choice < 3) begin
               send_item(evug_pkg::KIND_ABORT, 16'($urandom), 16'($urandom), 1'($urandom),
                         1'($urandom));
            end else if (choice < 11) begin
               send_item(evug_pkg::KIND_FRAME, 16'($urandom), 16'($urandom), 1'($urandom),
                         1'($urandom));
            end else begin
               if (loud) begin
                  hi = int'(cfg_thr) * 3 + 60;
                  if (hi > 32767) hi = 32767;
                  m = $urandom_range(int'(cfg_thr), hi);
               end else begin
                  m = $urandom_range(0, int'(cfg_thr) / 2);
               end
               jit = $urandom_range(0, m / 4);
               a = m;
               b = m - jit;
               if ($urandom_range(0, 1) == 1) begin
                  a = -a;
                  b = -b;
               end
               if ($urandom_range(0, 1) == 1) begin
                  t = a;
                  a = b;
                  b = t;
               end
               send_item(evug_pkg::KIND_FRAME, 16'(a), 16'(b), (i == len - 1),
                         (i == len - 1) ? hold : 1'($urandom_range(0, 1)));
            end
            sent++;
         end
      end
      // close the open block before any register write
      send_item(evug_pkg::KIND_FRAME, 16'd0, 16'd0, 1'b1, 1'b0);
   endtask

   initial begin
      stim_row_type row;
      cfg_thr = evug_pkg::THRESHOLD_RESET;
      cfg_mix = evug_pkg::MIX_MODE_RESET;
      cfg_sil = evug_pkg::SILENCE_BLOCKS_RESET;
      cfg_min = evug_pkg::MIN_SPEECH_RESET;
      cfg_max = evug_pkg::MAX_BLOCKS_RESET;
      clear_gate_state();

      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_ABORT, 0, 0, 1'b0, 1'b0),
                                  exp_rsp(0, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_ABORTED)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, 32767, 32767, 1'b0, 1'b0),
                                  exp_rsp(32767, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, -32768, -32768, 1'b0,
                                            1'b1),
                                  exp_rsp(-32768, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, 32767, -32768, 1'b0, 1'b0),
                                  exp_rsp(0, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, -3, 0, 1'b0, 1'b0),
                                  exp_rsp(-1, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 1000, 1000, 1'b1, 1'b1));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, 0, 0, 1'b1, 1'b0),
                                  exp_rsp(0, 1'b1, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 500, 500, 1'b1, 1'b0));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, -600, -400, 1'b1, 1'b1));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 300, 200, 1'b1, 1'b0));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 1, -1, 1'b1, 1'b0));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_ABORT, -1, 1, 1'b1, 1'b1),
                                  exp_rsp(0, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_ABORTED)));
      directed_rows.push_back(csr_row(evug_pkg::CSR_MIX_MODE, int'(evug_pkg::MIX_LOUDER)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, -5, 3, 1'b0, 1'b0),
                                  exp_rsp(-5, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, 4, -4, 1'b0, 1'b0),
                                  exp_rsp(4, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, -32768, 32767, 1'b0, 1'b0),
                                  exp_rsp(-32768, 1'b0, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_RUNNING)));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 7, -9, 1'b1, 1'b0));
      directed_rows.push_back(csr_row(evug_pkg::CSR_SILENCE_BLOCKS_NEEDED, 0));
      directed_rows.push_back(csr_row(evug_pkg::CSR_MIN_SPEECH_BLOCKS, 0));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 200, 0, 1'b1, 1'b0));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 0, 0, 1'b1, 1'b0));
      directed_rows.push_back(csr_row(evug_pkg::CSR_MAX_BLOCKS, 1));
      directed_rows.push_back(pin(frame_row(evug_pkg::KIND_FRAME, 0, 0, 1'b1, 1'b0),
                                  exp_rsp(0, 1'b1, 1'b0, 1'b0, 1'b0,
                                          evug_pkg::STATUS_NO_SPEECH)));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 9000, 9000, 1'b1, 1'b0));
      directed_rows.push_back(csr_row(evug_pkg::CSR_ENERGY_THRESHOLD, 0));
      directed_rows.push_back(frame_row(evug_pkg::KIND_FRAME, 0, 0, 1'b1, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            settle();
            write_reg(row.idx, int'(row.data));
         end else begin
            send_item(row.kind, row.left_s, row.right_s, row.last_blk, row.holdoff,
                      row.pinned, row.want);
         end
      end

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: set_gate_cfg(0, 0, 2, 1, 20);
            1: set_gate_cfg(32767, 1, 1, 1, 10);
            2: set_gate_cfg(120, 0, 255, 255, 65535);
            3: set_gate_cfg(300, 1, 0, 0, 1);
            default: begin
               set_gate_cfg($urandom_range(10, 2000), $urandom_range(0, 1),
                            $urandom_range(0, 6), $urandom_range(0, 5),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(100, 65535)
                                                        : $urandom_range(2, 40));
            end
         endcase
         calm = (p == 5);
         random_phase(110);
      end
      calm = 1'b0;

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/evug_pkg.sv
hw/rtl/evug_front.sv
hw/rtl/evug_core.sv
hw/rtl/energy_vad_utterance_gate.sv
tb/sv/tb_top.sv
